@@ design/hebbian_synapse_update_unit_macros.svh @@
// Assertion macros for the Hebbian synapse update unit
`ifndef HEBBIAN_SYNAPSE_UPDATE_UNIT_MACROS_SVH
`define HEBBIAN_SYNAPSE_UPDATE_UNIT_MACROS_SVH
`ifndef SYNTH
`define HSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define HSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/hsu_pkg.sv @@
// Shared constants for the Hebbian synapse update unit
package hsu_pkg;
   localparam logic [1:0] RULE_REWARD = 2'd0;
   localparam logic [1:0] RULE_SIGN   = 2'd1;
   localparam logic [1:0] RULE_STAB   = 2'd2;

   localparam logic [2:0] SCALE_OJA   = 3'd0;
   localparam logic [2:0] SCALE_TURR  = 3'd1;
   localparam logic [2:0] SCALE_HOME  = 3'd2;
   localparam logic [2:0] SCALE_HOMEP = 3'd3;
   localparam logic [2:0] SCALE_NONE  = 3'd4;

   localparam logic [2:0] CSR_RULE   = 3'd0;
   localparam logic [2:0] CSR_SCALE  = 3'd1;
   localparam logic [2:0] CSR_KMEAN  = 3'd2;
   localparam logic [2:0] CSR_WLIM   = 3'd3;
   localparam logic [2:0] CSR_WRECIP = 3'd4;
   localparam logic [2:0] CSR_GATE   = 3'd5;
endpackage

@@ design/hebbian_synapse_update_unit.sv @@
// Top level of the Hebbian synapse update unit: a streaming weight-update pipeline
//
// Use: drive one synapse per transfer on the req_ channel (valid/stall); the new
// weight, the soft-limited change and the scaling-idle flag come back on rsp_.
// Settings are written on the csr_ channel (index/data, valid/ready); the user
// must write them only while idle, which the block itself does not enforce;
// csr_ready is always high. A req transfer enters the first stage register, and
// its result leaves the last stage register on rsp_.
// Throughput: one item per cycle; each stage holds one item, and the stages
// advance together, gated by rsp_stall (at most one product layer per stage).
// When the output stage holds an item and rsp_stall is high the whole pipeline
// holds, so req_stall follows rsp_stall whenever the output stage holds an item.
// Reset (synchronous, active high) empties the pipeline and restores the
// settings to rule 2, scaling mode 3, limit 10.0 and reciprocal 0.1.
// Every product is rounded to nearest (ties up) and saturated; sums saturate.
module hebbian_synapse_update_unit #(
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_pre_activity,
   input  logic signed [VALUE_WIDTH-1:0] req_post_activity,
   input  logic signed [VALUE_WIDTH-1:0] req_pre_mean,
   input  logic signed [VALUE_WIDTH-1:0] req_post_mean,
   input  logic signed [VALUE_WIDTH-1:0] req_old_weight,
   input  logic signed [VALUE_WIDTH-1:0] req_learn_rate,
   input  logic signed [VALUE_WIDTH-1:0] req_pre_term_gain,
   input  logic signed [VALUE_WIDTH-1:0] req_post_term_gain,
   input  logic signed [VALUE_WIDTH-1:0] req_scaling_gain,
   input  logic signed [VALUE_WIDTH-1:0] req_decay_rate,
   input  logic signed [VALUE_WIDTH-1:0] req_reward_signal,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_new_weight,
   output logic signed [VALUE_WIDTH-1:0] rsp_applied_change,
   output logic                          rsp_scaling_idle,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [2:0]                    csr_index,
   input  logic [VALUE_WIDTH-1:0]        csr_data
);
`include "hebbian_synapse_update_unit_macros.svh"

   localparam int W = VALUE_WIDTH;
   localparam int F = FRACTION_BITS;
   localparam int P = 2 * W;
   localparam int NST = 12;
   localparam longint VMAXL = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam longint ONEL = 64'sd1 <<< F;

   // clip a positive constant to the value range
   function automatic longint csat(longint v);
      csat = (v > VMAXL) ? VMAXL : v;
   endfunction

   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] QONE = W'(csat(ONEL));
   localparam logic signed [W-1:0] Q1 = W'(csat(ONEL >>> 2));
   localparam logic signed [W-1:0] Q3 = W'(csat((64'sd3 * ONEL) >>> 2));
   localparam logic signed [W-1:0] QH = W'(csat(ONEL >>> 1));
   localparam logic [W-2:0] WLIM_RST = (W-1)'(csat(64'sd10 * ONEL));
   localparam logic [W-2:0] WRECIP_RST = (W-1)'(csat((ONEL + 64'sd5) / 64'sd10));

   typedef logic signed [W-1:0] val_type;

   // saturating fixed-point primitives
   function automatic val_type qmul(val_type a, val_type b);
      logic signed [P:0] pr;
      logic signed [P:0] sh;
      begin
         pr = (P+1)'(a) * (P+1)'(b) + ((P+1)'(1) <<< (F - 1));
         sh = pr >>> F;
         if (sh > (P+1)'(VMAX)) qmul = VMAX;
         else if (sh < (P+1)'(VMIN)) qmul = VMIN;
         else qmul = sh[W-1:0];
      end
   endfunction

   function automatic val_type qsat(logic signed [W+5:0] v);
      begin
         if (v > (W+6)'(VMAX)) qsat = VMAX;
         else if (v < (W+6)'(VMIN)) qsat = VMIN;
         else qsat = v[W-1:0];
      end
   endfunction

   function automatic val_type qadd(val_type a, val_type b);
      qadd = qsat((W+6)'(a) + (W+6)'(b));
   endfunction

   function automatic val_type qsub(val_type a, val_type b);
      qsub = qsat((W+6)'(a) - (W+6)'(b));
   endfunction

   function automatic val_type qneg(val_type v);
      qneg = (v == VMIN) ? VMAX : -v;
   endfunction

   function automatic val_type qabs(val_type v);
      qabs = v[W-1] ? qneg(v) : v;
   endfunction

   function automatic val_type bysign(val_type v, val_type s);
      begin
         if (s == '0) bysign = '0;
         else if (s[W-1]) bysign = qneg(v);
         else bysign = v;
      end
   endfunction

   // configuration registers
   logic [1:0]   rule_ff;
   logic [2:0]   scale_ff;
   val_type      kmean_ff;
   logic [W-2:0] wlim_ff;
   logic [W-2:0] wrecip_ff;
   logic         gate_ff;

   assign csr_ready = 1'b1;

   // take a configuration transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= hsu_pkg::RULE_STAB;
         scale_ff  <= hsu_pkg::SCALE_HOMEP;
         kmean_ff  <= '0;
         wlim_ff   <= WLIM_RST;
         wrecip_ff <= WRECIP_RST;
         gate_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            hsu_pkg::CSR_RULE:   rule_ff   <= csr_data[1:0];
            hsu_pkg::CSR_SCALE:  scale_ff  <= csr_data[2:0];
            hsu_pkg::CSR_KMEAN:  kmean_ff  <= csr_data;
            hsu_pkg::CSR_WLIM:   wlim_ff   <= csr_data[W-2:0];
            hsu_pkg::CSR_WRECIP: wrecip_ff <= csr_data[W-2:0];
            hsu_pkg::CSR_GATE:   gate_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control: all stages advance together unless output stalls
   logic [NST-1:0] vld_ff, vld_in;
   logic           adv;
   assign adv = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      vld_in = {vld_ff[NST-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // per-stage payload
   typedef struct packed {
      val_type x, y, mx, my, w, lr, pg, qg, sg, dc, r;
      val_type a, b, t0, t1, t2, t3, t4, e, s, d, l, nw;
      logic    idle;
   } pay_type;

   pay_type st_ff [NST];
   pay_type st_in [NST];

   logic home_lo, home_hi;

   // stage logic, at most one product layer per stage
   always_comb begin
      st_in[0] = '0;
      st_in[0].x  = req_pre_activity;
      st_in[0].y  = req_post_activity;
      st_in[0].mx = req_pre_mean;
      st_in[0].my = req_post_mean;
      st_in[0].w  = req_old_weight;
      st_in[0].lr = req_learn_rate;
      st_in[0].pg = req_pre_term_gain;
      st_in[0].qg = req_post_term_gain;
      st_in[0].sg = req_scaling_gain;
      st_in[0].dc = req_decay_rate;
      st_in[0].r  = req_reward_signal;
      // k*mx, y-my, my-0.25/0.75 difference
      st_in[0].t0 = qmul(kmean_ff, req_pre_mean);
      st_in[0].b  = qsub(req_post_activity, req_post_mean);
      st_in[0].t1 = (req_post_mean < Q1) ? qsub(req_post_mean, Q1) :
                    qsub(req_post_mean, Q3);
      home_lo = 1'b0;
      home_hi = 1'b0;

      // stage 1: a, x*b, pg*x, qg*y, difference squared, w*w, my*my, |w|*reciprocal
      st_in[1] = st_ff[0];
      st_in[1].a  = qsub(st_ff[0].x, st_ff[0].t0);
      st_in[1].t0 = qmul(st_ff[0].x, st_ff[0].b);
      st_in[1].t2 = qmul(st_ff[0].pg, st_ff[0].x);
      st_in[1].t3 = qmul(st_ff[0].qg, st_ff[0].y);
      st_in[1].t1 = qmul(st_ff[0].t1, st_ff[0].t1);
      st_in[1].t4 = qmul(st_ff[0].w, st_ff[0].w);
      st_in[1].s  = qmul(st_ff[0].my, st_ff[0].my);
      st_in[1].l  = qmul(qabs(st_ff[0].w), $signed({1'b0, wrecip_ff}));

      // stage 2: rule products, homeostatic factor, Oja/Turrigiano raw, soft-limit factor
      st_in[2] = st_ff[1];
      home_lo = st_ff[1].my < Q1;
      home_hi = st_ff[1].my > Q3;
      case (rule_ff)
         hsu_pkg::RULE_SIGN:
            st_in[2].e = qmul(bysign(st_ff[1].lr, st_ff[1].r), st_ff[1].t0);
         hsu_pkg::RULE_STAB:
            st_in[2].e = qmul(st_ff[1].lr, st_ff[1].a);
         default:
            st_in[2].e = qmul(st_ff[1].lr, st_ff[1].r);
      endcase
      st_in[2].t0 = (rule_ff == hsu_pkg::RULE_STAB) ?
                    qmul(st_ff[1].lr, qadd(st_ff[1].t2, st_ff[1].t3)) :
                    qmul(st_ff[1].a, st_ff[1].b);
      if (home_lo)
         st_in[2].t1 = qsat((W+6)'(st_ff[1].t1) <<< 4);
      else if (home_hi)
         st_in[2].t1 = qsat(-((W+6)'(st_ff[1].t1) <<< 4));
      else
         st_in[2].t1 = '0;
      case (scale_ff)
         hsu_pkg::SCALE_OJA:
            st_in[2].s = qmul(qneg(st_ff[1].w), st_ff[1].s);
         hsu_pkg::SCALE_TURR:
            st_in[2].s = qmul(qsub(QH, st_ff[1].my), qabs(st_ff[1].w));
         default:
            st_in[2].s = '0;
      endcase
      st_in[2].l = qsub(QONE, st_ff[1].l);

      // stage 3: finish Hebbian term, homeostatic factor times w*w
      st_in[3] = st_ff[2];
      if (rule_ff == hsu_pkg::RULE_STAB)
         st_in[3].e = qmul(st_ff[2].e, st_ff[2].b);
      else if (rule_ff == hsu_pkg::RULE_SIGN)
         st_in[3].e = st_ff[2].e;
      else
         st_in[3].e = qmul(st_ff[2].e, st_ff[2].t0);
      st_in[3].t1 = qmul(st_ff[2].t1, st_ff[2].t4);

      // stage 4: stabilised sum and gate, presynaptic factor
      st_in[4] = st_ff[3];
      if (rule_ff == hsu_pkg::RULE_STAB) begin
         st_in[4].e = qadd(st_ff[3].e, st_ff[3].t0);
         if (gate_ff) st_in[4].e = bysign(qadd(st_ff[3].e, st_ff[3].t0), st_ff[3].r);
      end
      case (scale_ff)
         hsu_pkg::SCALE_HOME:  st_in[4].s = st_ff[3].t1;
         hsu_pkg::SCALE_HOMEP: st_in[4].s = qmul(st_ff[3].t1, st_ff[3].mx);
         default: ;
      endcase

      // stage 5: scaling term times gain, decay product
      st_in[5] = st_ff[4];
      st_in[5].s  = qmul(st_ff[4].s, st_ff[4].sg);
      st_in[5].t2 = qmul(st_ff[4].dc, st_ff[4].w);

      // stage 6: scaling-idle flag, combine change
      st_in[6] = st_ff[5];
      st_in[6].idle = (st_ff[5].s == '0);
      st_in[6].d = qadd(st_ff[5].e, st_ff[5].s);

      // stage 7: decay when scaling idle in the stabilised rule
      st_in[7] = st_ff[6];
      if (rule_ff == hsu_pkg::RULE_STAB && st_ff[6].idle)
         st_in[7].d = qsub(st_ff[6].d, st_ff[6].t2);

      // stage 8: soft limit
      st_in[8] = st_ff[7];
      st_in[8].d = qmul(st_ff[7].d, st_ff[7].l);

      // stage 9: add to weight
      st_in[9] = st_ff[8];
      st_in[9].nw = qadd(st_ff[8].w, st_ff[8].d);

      // stage 10: clamp high
      st_in[10] = st_ff[9];
      if ((W+1)'(st_ff[9].nw) > $signed({2'b00, wlim_ff}))
         st_in[10].nw = $signed({1'b0, wlim_ff});

      // stage 11: clamp low
      st_in[11] = st_ff[10];
      if ((W+1)'(st_ff[10].nw) < -$signed({2'b00, wlim_ff}))
         st_in[11].nw = -$signed({1'b0, wlim_ff});
   end

   // advance payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NST; i++) st_ff[i] <= st_in[i];
      end
   end

   assign rsp_valid          = vld_ff[NST-1];
   assign rsp_new_weight     = st_ff[NST-1].nw;
   assign rsp_applied_change = st_ff[NST-1].d;
   assign rsp_scaling_idle   = st_ff[NST-1].idle;

   // checks
   `HSU_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_weight))
   `HSU_ASSERT_IMPL(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
   `HSU_ASSERT_IMPL(a_clamp, clock, reset, rsp_valid, (W+1)'(rsp_new_weight) <= $signed({2'b00, wlim_ff}))
endmodule
